// ----- rtl/core/inverse_dwt53_horizontal_line_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the inverse 5/3 horizontal line block
// Implication checks, same cycle and next cycle, with reset disable.
// ----------------------------------------------------------------------------
`ifndef INVERSE_DWT53_HORIZONTAL_LINE_ASSERT_SVH
`define INVERSE_DWT53_HORIZONTAL_LINE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IDWT53_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("idwt53: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define IDWT53_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("idwt53: next-cycle check failed");

`endif

// ----- rtl/core/idwt53_pkg.sv -----
// ----------------------------------------------------------------------------
// idwt53_pkg
// Widths, register indexes and shared types of the inverse 5/3 line block.
// ----------------------------------------------------------------------------
`default_nettype none

package idwt53_pkg;

	localparam int LINE_LEN_W = 14;
	localparam int SHIFT_W    = 5;
	localparam int LOW_W      = 32;
	localparam int HIGH_W     = 16;
	localparam int SAMPLE_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SHIFT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND_NARROW = 2'd2;

	localparam logic [LINE_LEN_W-1:0] LINE_LENGTH_RST = 14'd2;
	localparam logic [SHIFT_W-1:0]    COEF_SHIFT_RST  = 5'd0;
	localparam logic                  NARROW_RST      = 1'b1;

	typedef struct packed {
		logic [LINE_LEN_W-1:0] line_length;
		logic [SHIFT_W-1:0]    coef_shift;
		logic                  low_band_narrow;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] e;
		logic [SAMPLE_W-1:0] h;
		logic [SAMPLE_W-1:0] prev_h;
		logic                emit_o;
		logic                emit_eh;
		logic                line_end;
	} lift_s2_t;

	typedef struct packed {
		logic [2:0][SAMPLE_W-1:0] slot;
		logic [1:0]               last_idx;
		logic                     line_end;
	} bundle_t;

endpackage

`default_nettype wire

// ----- rtl/core/idwt53_lift.sv -----
// ----------------------------------------------------------------------------
// idwt53_lift
// Input register, even-sample lifting stage and odd-sample lifting logic.
// ----------------------------------------------------------------------------
`default_nettype none

module idwt53_lift #(
	parameter int MAX_LINE_LEN = 8192
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  idwt53_pkg::cfg_t               cfg,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [idwt53_pkg::LOW_W-1:0]   low_coef,
	input  wire  [idwt53_pkg::HIGH_W-1:0]  high_coef,
	output logic                           bnd_valid,
	input  wire                            bnd_ready,
	output idwt53_pkg::bundle_t            bnd
);
	import idwt53_pkg::*;

	localparam int LEN_BITS = $clog2(MAX_LINE_LEN + 1);
	localparam int LEN_W    = (LEN_BITS > LINE_LEN_W) ? LEN_BITS : LINE_LEN_W;
	localparam int POS_W    = $clog2((MAX_LINE_LEN + 1) / 2 + 1);

	logic                v_s1;
	logic [LOW_W-1:0]    low_s1;
	logic [HIGH_W-1:0]   high_s1;
	logic                v_s2;
	lift_s2_t            lift_s2;
	logic [POS_W-1:0]    pos_q;
	logic [SAMPLE_W-1:0] prev_h_q;
	logic [SAMPLE_W-1:0] prev_e_q;

	logic                adv_s2;
	logic [SAMPLE_W-1:0] h, l, a, b, c, sum, q, e;
	logic [LEN_W-1:0]    len_raw, len_c, pairs, last, pos_c;
	logic                odd, first, middle, line_end;
	lift_s2_t            lift_d;
	logic [SAMPLE_W-1:0] pair_sum, o, eh;

	assign adv_s2    = v_s1 && (!v_s2 || bnd_ready);
	assign in_ready  = !v_s1 || adv_s2;
	assign bnd_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			low_s1  <= low_coef;
			high_s1 <= high_coef;
		end
	end

	always_comb begin
		h = {{(SAMPLE_W-HIGH_W){high_s1[HIGH_W-1]}}, high_s1} << cfg.coef_shift;
		if (cfg.low_band_narrow) begin
			l = {{(SAMPLE_W-16){low_s1[15]}}, low_s1[15:0]} << cfg.coef_shift;
		end else begin
			l = low_s1;
		end

		len_raw = LEN_W'(cfg.line_length);
		if (len_raw < LEN_W'(2)) begin
			len_c = LEN_W'(2);
		end else if (len_raw > LEN_W'(MAX_LINE_LEN)) begin
			len_c = LEN_W'(MAX_LINE_LEN);
		end else begin
			len_c = len_raw;
		end
		pairs = len_c >> 1;
		odd   = len_c[0];
		last  = pairs - LEN_W'(1) + LEN_W'(odd);
		pos_c = (LEN_W'(pos_q) > last) ? last : LEN_W'(pos_q);

		first    = (pos_c == '0);
		middle   = !first && (pos_c < pairs);
		line_end = (pos_c == last);

		a   = first ? h : prev_h_q;
		b   = middle ? h : '0;
		c   = middle ? SAMPLE_W'(2) : SAMPLE_W'(1);
		sum = a + b + c;
		q   = middle ? SAMPLE_W'($signed(sum) >>> 2) : SAMPLE_W'($signed(sum) >>> 1);
		e   = l - q;

		lift_d.e        = e;
		lift_d.h        = h;
		lift_d.prev_h   = prev_h_q;
		lift_d.emit_o   = !first;
		lift_d.emit_eh  = !odd && (pos_c == pairs - LEN_W'(1));
		lift_d.line_end = line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			pos_q    <= '0;
			prev_h_q <= '0;
			prev_e_q <= '0;
		end else begin
			if (!v_s2 || bnd_ready) begin
				v_s2 <= v_s1;
			end
			if (adv_s2) begin
				prev_h_q <= h;
				pos_q    <= line_end ? '0 : POS_W'(pos_c + LEN_W'(1));
			end
			if (v_s2 && bnd_ready) begin
				prev_e_q <= lift_s2.e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			lift_s2 <= lift_d;
		end
	end

	always_comb begin
		pair_sum = prev_e_q + lift_s2.e;
		o        = lift_s2.prev_h + SAMPLE_W'($signed(pair_sum) >>> 1);
		eh       = lift_s2.h + lift_s2.e;
		if (lift_s2.emit_o) begin
			bnd.slot = {eh, lift_s2.e, o};
		end else begin
			bnd.slot = {eh, eh, lift_s2.e};
		end
		bnd.last_idx = {1'b0, lift_s2.emit_o} + {1'b0, lift_s2.emit_eh};
		bnd.line_end = lift_s2.line_end;
	end

endmodule

`default_nettype wire

// ----- rtl/core/idwt53_ser.sv -----
// ----------------------------------------------------------------------------
// idwt53_ser
// Result register; sends the one to three samples of an item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module idwt53_ser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              bnd_valid,
	output logic                             bnd_ready,
	input  idwt53_pkg::bundle_t              bnd,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [idwt53_pkg::SAMPLE_W-1:0]  sample,
	output logic                             item_last,
	output logic                             line_last
);
	import idwt53_pkg::*;

	logic       v_s3;
	bundle_t    bnd_s3;
	logic [1:0] idx_q;
	logic       take;

	assign out_valid = v_s3;
	assign take      = v_s3 && out_ready;
	assign item_last = (idx_q == bnd_s3.last_idx);
	assign line_last = item_last && bnd_s3.line_end;
	assign bnd_ready = !v_s3 || (take && item_last);

	always_comb begin
		case (idx_q)
			2'd0:    sample = bnd_s3.slot[0];
			2'd1:    sample = bnd_s3.slot[1];
			default: sample = bnd_s3.slot[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (bnd_ready) begin
				v_s3 <= bnd_valid;
			end
			if (take) begin
				idx_q <= item_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_ready && bnd_valid) begin
			bnd_s3 <= bnd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/inverse_dwt53_horizontal_line.sv -----
// ----------------------------------------------------------------------------
// inverse_dwt53_horizontal_line
// Horizontal inverse 5/3 lifting of one line from low/high coefficient pairs.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   low_coef, high_coef (one pair)
//  out      out_valid / out_ready sample, item_last, line_last
//  cfg      cfg_wen               cfg_index, cfg_wdata
//
// Each pair yields one to three samples, one sample per cycle at the output
// while out_ready is high, so the output port sets the pace of a line.
// A pair's first sample leaves after the input, lifting and result registers.
// Asynchronous reset restores the register defaults and the start of line.
// Input and output stalls are absorbed by the input, lifting and result
// registers; a new pair is taken while results of earlier ones wait.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_dwt53_horizontal_line #(
	parameter int MAX_LINE_LEN = 8192
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wen,
	input  wire  [idwt53_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [idwt53_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [idwt53_pkg::LOW_W-1:0]       low_coef,
	input  wire  [idwt53_pkg::HIGH_W-1:0]      high_coef,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [idwt53_pkg::SAMPLE_W-1:0]    sample,
	output logic                               item_last,
	output logic                               line_last
);
	import idwt53_pkg::*;

	cfg_t    cfg_q;
	logic    bnd_valid;
	logic    bnd_ready;
	bundle_t bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length     <= LINE_LENGTH_RST;
			cfg_q.coef_shift      <= COEF_SHIFT_RST;
			cfg_q.low_band_narrow <= NARROW_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LINE_LENGTH:     cfg_q.line_length     <= cfg_wdata[LINE_LEN_W-1:0];
				REG_COEF_SHIFT:      cfg_q.coef_shift      <= cfg_wdata[SHIFT_W-1:0];
				REG_LOW_BAND_NARROW: cfg_q.low_band_narrow <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	idwt53_lift #(
		.MAX_LINE_LEN(MAX_LINE_LEN)
	) u_lift (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.low_coef  (low_coef),
		.high_coef (high_coef),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd)
	);

	idwt53_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.item_last (item_last),
		.line_last (line_last)
	);

endmodule

`default_nettype wire

// ----- rtl/core/idwt53_chk.sv -----
// ----------------------------------------------------------------------------
// idwt53_chk
// Port-level checks of the inverse 5/3 line block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "inverse_dwt53_horizontal_line_assert.svh"

module idwt53_chk (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_valid,
	input wire                               in_ready,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire [idwt53_pkg::SAMPLE_W-1:0]    sample,
	input wire                               item_last,
	input wire                               line_last
);
	logic       in_acc;
	logic       item_done;
	logic [2:0] pending_q;

	assign in_acc    = in_valid && in_ready;
	assign item_done = out_valid && out_ready && item_last;

	// transactions in flight: accepted pairs whose last sample is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(item_done);
		end
	end

	`IDWT53_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample))
	`IDWT53_ASSERT_IMPLY(a_line_ends_item, clk, arst_n, out_valid && line_last, item_last)
	`IDWT53_ASSERT_IMPLY(a_no_orphan_result, clk, arst_n, out_valid, pending_q != 3'd0)
	`IDWT53_ASSERT_IMPLY(a_pending_bound, clk, arst_n, 1'b1, pending_q <= 3'd3)

endmodule

bind inverse_dwt53_horizontal_line idwt53_chk u_idwt53_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample),
	.item_last (item_last),
	.line_last (line_last)
);

`default_nettype wire
